// File: src/mpwd_pkg.sv
// ----------------------------------------------------------------------------
// mpwd_pkg
// Shared types and constants for the Manchester pulse-width decoder.
// ----------------------------------------------------------------------------
package mpwd_pkg;

    localparam int unsigned WidthW = 16;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 4;
    localparam int unsigned IndexW = 3;

    localparam logic [ByteW-1:0]  ByteMsb  = 8'h80;
    localparam logic [CountW-1:0] BitsFull = 4'd8;

    typedef enum logic [IndexW-1:0] {
        REG_SHORT_LOW    = 3'd0,
        REG_SHORT_HIGH   = 3'd1,
        REG_LONG_LOW     = 3'd2,
        REG_LONG_HIGH    = 3'd3,
        REG_START_BYTE   = 3'd4,
        REG_FRAME_LENGTH = 3'd5
    } reg_index_t;

    localparam logic [WidthW-1:0] ShortLowRst    = 16'd999;
    localparam logic [WidthW-1:0] ShortHighRst   = 16'd2332;
    localparam logic [WidthW-1:0] LongLowRst     = 16'd1999;
    localparam logic [WidthW-1:0] LongHighRst    = 16'd4666;
    localparam logic [ByteW-1:0]  StartByteRst   = 8'd36;
    localparam logic [ByteW-1:0]  FrameLengthRst = 8'd6;

    typedef struct packed {
        logic [WidthW-1:0] short_low;
        logic [WidthW-1:0] short_high;
        logic [WidthW-1:0] long_low;
        logic [WidthW-1:0] long_high;
        logic [ByteW-1:0]  start_byte;
        logic [ByteW-1:0]  frame_length;
    } cfg_t;

    typedef struct packed {
        logic              in_sync;
        logic              half_seen;
        logic [ByteW-1:0]  shift_byte;
        logic [CountW-1:0] bit_count;
        logic [ByteW-1:0]  byte_count;
        logic              capturing;
    } dec_state_t;

    typedef struct packed {
        logic [WidthW-1:0] width_ticks;
        logic              edge_rising;
    } pulse_t;

    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data_byte;
        logic             frame_done;
    } result_t;

endpackage

// File: src/manchester_pulse_width_decoder_unit.sv
// ----------------------------------------------------------------------------
// manchester_pulse_width_decoder_unit
// Manchester decoder driven by measured pulse widths; emits framed bytes.
// ----------------------------------------------------------------------------
// An accepted pulse is held in the pulse register; its decoded byte, if any, then goes to the output register.
// Throughput: one pulse per cycle; the single decode stage and the output
// register set this, and an input waits only while both are full and stalled.
// Reset: decoder state clears and the configuration registers take their
// default windows, start byte '$' and frame length 6.
// ----------------------------------------------------------------------------
module manchester_pulse_width_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mpwd_pkg::WidthW-1:0]         width_ticks,
    input  logic                                edge_rising,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mpwd_pkg::ByteW-1:0]          data_byte,
    output logic                                frame_done,
    input  logic                                cfg_we,
    input  logic [mpwd_pkg::IndexW-1:0]         cfg_index,
    input  logic [mpwd_pkg::WidthW-1:0]         cfg_data
);

    mpwd_pkg::cfg_t       cfg;
    mpwd_pkg::dec_state_t state_reg;
    mpwd_pkg::dec_state_t state_next;
    mpwd_pkg::pulse_t     pulse_reg;
    mpwd_pkg::result_t    step_res;
    logic                 in_v_reg;
    logic                 out_v_reg;
    logic [mpwd_pkg::ByteW-1:0] data_reg;
    logic                 done_reg;
    logic                 advance;
    logic                 in_take;

    mpwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpwd_step u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .pulse   (pulse_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    assign advance  = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (in_take)
                in_v_reg <= 1'b1;
            else if (advance)
                in_v_reg <= 1'b0;

            if (advance)
            begin
                state_reg <= state_next;
                out_v_reg <= step_res.valid;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pulse_reg.width_ticks <= width_ticks;
            pulse_reg.edge_rising <= edge_rising;
        end
        if (advance && step_res.valid)
        begin
            data_reg <= step_res.data_byte;
            done_reg <= step_res.frame_done;
        end
    end

    assign out_valid  = out_v_reg;
    assign data_byte  = data_reg;
    assign frame_done = done_reg;

    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count < mpwd_pkg::BitsFull)
        else $error("bit count reached a full byte without clearing");

    a_frame_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid && step_res.frame_done)
        |=> (!state_reg.in_sync && !state_reg.capturing))
        else $error("frame end did not return to hunting");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid) |=> out_valid)
        else $error("decoded byte lost before the output register");

    a_byte_needs_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.valid && !step_res.frame_done) |=> state_reg.capturing)
        else $error("byte output without capture held");

endmodule

// File: src/mpwd_cfg.sv
// ----------------------------------------------------------------------------
// mpwd_cfg
// Configuration register file: pulse windows, start byte and frame length.
// ----------------------------------------------------------------------------
module mpwd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpwd_pkg::IndexW-1:0]   cfg_index,
    input  logic [mpwd_pkg::WidthW-1:0]   cfg_data,
    output mpwd_pkg::cfg_t                cfg
);

    mpwd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_low    <= mpwd_pkg::ShortLowRst;
            cfg_reg.short_high   <= mpwd_pkg::ShortHighRst;
            cfg_reg.long_low     <= mpwd_pkg::LongLowRst;
            cfg_reg.long_high    <= mpwd_pkg::LongHighRst;
            cfg_reg.start_byte   <= mpwd_pkg::StartByteRst;
            cfg_reg.frame_length <= mpwd_pkg::FrameLengthRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mpwd_pkg::REG_SHORT_LOW:    cfg_reg.short_low    <= cfg_data;
                mpwd_pkg::REG_SHORT_HIGH:   cfg_reg.short_high   <= cfg_data;
                mpwd_pkg::REG_LONG_LOW:     cfg_reg.long_low     <= cfg_data;
                mpwd_pkg::REG_LONG_HIGH:    cfg_reg.long_high    <= cfg_data;
                mpwd_pkg::REG_START_BYTE:   cfg_reg.start_byte   <= cfg_data[mpwd_pkg::ByteW-1:0];
                mpwd_pkg::REG_FRAME_LENGTH: cfg_reg.frame_length <= cfg_data[mpwd_pkg::ByteW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/mpwd_step.sv
// ----------------------------------------------------------------------------
// mpwd_step
// Per-pulse decode: window tests, sync tracking, bit shift and byte output.
// ----------------------------------------------------------------------------
module mpwd_step (
    input  mpwd_pkg::cfg_t       cfg,
    input  mpwd_pkg::dec_state_t st,
    input  mpwd_pkg::pulse_t     pulse,
    output mpwd_pkg::dec_state_t st_next,
    output mpwd_pkg::result_t    res
);

    logic                                is_short;
    logic                                is_long;
    logic                                shift_en;
    logic                                capture;
    logic [mpwd_pkg::ByteW-1:0]          sb;
    logic [mpwd_pkg::CountW-1:0]         bc;
    logic [mpwd_pkg::ByteW-1:0]          bytes;

    assign is_short = (pulse.width_ticks > cfg.short_low) && (pulse.width_ticks < cfg.short_high);
    assign is_long  = (pulse.width_ticks > cfg.long_low) && (pulse.width_ticks < cfg.long_high);

    always_comb
    begin
        st_next        = st;
        res.valid      = 1'b0;
        res.data_byte  = '0;
        res.frame_done = 1'b0;
        shift_en       = 1'b0;
        capture        = st.capturing;
        bytes          = st.byte_count;
        sb             = st.shift_byte;
        bc             = st.bit_count + 4'd1;

        if (!pulse.edge_rising && (st.bit_count < mpwd_pkg::BitsFull))
        begin
            sb = st.shift_byte | (mpwd_pkg::ByteMsb >> st.bit_count[2:0]);
        end

        priority if (!st.in_sync)
        begin
            if (is_long)
            begin
                st_next.half_seen  = 1'b0;
                st_next.shift_byte = '0;
                st_next.bit_count  = '0;
                st_next.byte_count = '0;
                st_next.in_sync    = 1'b1;
            end
        end
        else if (!st.half_seen)
        begin
            priority if (is_short)
                st_next.half_seen = 1'b1;
            else if (!is_long)
                st_next.in_sync = 1'b0;
            else
                shift_en = 1'b1;
        end
        else
        begin
            if (!is_short)
            begin
                st_next.in_sync = 1'b0;
            end
            else
            begin
                st_next.half_seen = 1'b0;
                shift_en          = 1'b1;
            end
        end

        if (shift_en)
        begin
            if (bc >= mpwd_pkg::BitsFull)
            begin
                capture = st.capturing || (sb == cfg.start_byte);
                if (capture)
                begin
                    bytes          = st.byte_count + 8'd1;
                    res.valid      = 1'b1;
                    res.data_byte  = sb;
                    res.frame_done = (bytes >= cfg.frame_length);
                end
                st_next.byte_count = bytes;
                st_next.shift_byte = '0;
                st_next.bit_count  = '0;
                st_next.capturing  = capture;
                if (bytes >= cfg.frame_length)
                begin
                    st_next.capturing = 1'b0;
                    st_next.in_sync   = 1'b0;
                end
            end
            else
            begin
                st_next.shift_byte = sb;
                st_next.bit_count  = bc;
            end
        end
    end

endmodule
